### sv/point_in_polygon_fan_test_core_assert.svh
// Assertion macros shared by the point-in-polygon fan test RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef POINT_IN_POLYGON_FAN_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_FAN_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PIPFT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pipft assertion failed");
`define PIPFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipft assertion failed");
`define PIPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipft assertion failed");
`else
`define PIPFT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PIPFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/pipft_pkg.sv
// Package for the point-in-polygon fan test core: sizes, codes and shared types.
// Used by pipft_area_pipe and point_in_polygon_fan_test_core.
package pipft_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int FUNC_W       = 2;
    localparam int IN_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_CNT_W    = 7;
    localparam int OUT_USED_W   = 1 + OUT_CNT_W + 1;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int AREA_W       = PROD_W + 1;
    localparam int SUM_W        = AREA_W + 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 2'd0,
        FN_QUERY  = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [AREA_W-1:0]  t_area;
    typedef logic [AREA_W-1:0]         t_area_u;
    typedef logic [SUM_W-1:0]          t_sum;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef struct packed {
        logic vld;
        logic last;
        t_pt  vn;
        t_pt  a;
        t_pt  b;
        t_pt  p;
    } t_tri_req;

    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_tri_res;

endpackage

### sv/pipft_area_pipe.sv
// Four-stage area pipeline: differences, products, absolute doubled areas, area-sum compare.
// Depends on pipft_pkg for the point, request and result types.
module pipft_area_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_flush,
    input  pipft_pkg::t_tri_req i_req,
    output pipft_pkg::t_tri_res o_res
);

    localparam int NA = 4;

    pipft_pkg::t_pt   w_ta [NA];
    pipft_pkg::t_pt   w_tb [NA];
    pipft_pkg::t_pt   w_tc [NA];
    pipft_pkg::t_diff w_d  [NA][4];

    pipft_pkg::t_diff   r_d  [NA][4];
    pipft_pkg::t_prod   r_m  [NA][2];
    pipft_pkg::t_area_u r_ar [NA];
    logic               r_d_vld, r_m_vld, r_ar_vld, r_res_vld;
    logic               r_d_last, r_m_last, r_ar_last, r_res_last;
    logic               r_res_hit;
    pipft_pkg::t_sum    w_part;

    function automatic pipft_pkg::t_area_u abs_diff(pipft_pkg::t_prod m0,
                                                    pipft_pkg::t_prod m1);
        pipft_pkg::t_area s;
        s = pipft_pkg::t_area'(m0) - pipft_pkg::t_area'(m1);
        return s[pipft_pkg::AREA_W-1] ? pipft_pkg::t_area_u'(-s) : pipft_pkg::t_area_u'(s);
    endfunction

    // The whole fan triangle, then the three sub-triangles formed with the point.
    always_comb begin
        w_ta[0] = i_req.a;  w_tb[0] = i_req.b;  w_tc[0] = i_req.vn;
        w_ta[1] = i_req.a;  w_tb[1] = i_req.b;  w_tc[1] = i_req.p;
        w_ta[2] = i_req.vn; w_tb[2] = i_req.b;  w_tc[2] = i_req.p;
        w_ta[3] = i_req.a;  w_tb[3] = i_req.vn; w_tc[3] = i_req.p;
        for (int j = 0; j < NA; j++) begin
            w_d[j][0] = pipft_pkg::t_diff'(w_tb[j].x) - pipft_pkg::t_diff'(w_ta[j].x);
            w_d[j][1] = pipft_pkg::t_diff'(w_tc[j].y) - pipft_pkg::t_diff'(w_ta[j].y);
            w_d[j][2] = pipft_pkg::t_diff'(w_tb[j].y) - pipft_pkg::t_diff'(w_ta[j].y);
            w_d[j][3] = pipft_pkg::t_diff'(w_tc[j].x) - pipft_pkg::t_diff'(w_ta[j].x);
        end
    end

    assign w_part = pipft_pkg::t_sum'(r_ar[1]) + pipft_pkg::t_sum'(r_ar[2])
                  + pipft_pkg::t_sum'(r_ar[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_d_vld   <= 1'b0;
            r_m_vld   <= 1'b0;
            r_ar_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_d_vld   <= i_req.vld;
            r_m_vld   <= r_d_vld;
            r_ar_vld  <= r_m_vld;
            r_res_vld <= r_ar_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_last   <= i_req.last;
        r_m_last   <= r_d_last;
        r_ar_last  <= r_m_last;
        r_res_last <= r_ar_last;
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < 4; k++) begin
                r_d[j][k] <= w_d[j][k];
            end
            r_m[j][0] <= pipft_pkg::t_prod'(r_d[j][0]) * pipft_pkg::t_prod'(r_d[j][1]);
            r_m[j][1] <= pipft_pkg::t_prod'(r_d[j][2]) * pipft_pkg::t_prod'(r_d[j][3]);
            r_ar[j]   <= abs_diff(r_m[j][0], r_m[j][1]);
        end
        r_res_hit <= (pipft_pkg::t_sum'(r_ar[0]) == w_part);
    end

    assign o_res.vld  = r_res_vld;
    assign o_res.last = r_res_last;
    assign o_res.hit  = r_res_hit;

endmodule

### sv/point_in_polygon_fan_test_core.sv
// Top level of the point-in-polygon fan test: vertex memory, walk sequencer, stream ports.
// Depends on pipft_pkg, pipft_area_pipe and point_in_polygon_fan_test_core_assert.svh.
//
// Append, clear and unused codes give their result word in the cycle after the input word is
// taken. A query with N stored vertices (N of two or more) walks up to N fans; each fan
// streams N+1 vertices out of the single read port of the vertex memory, one a cycle, into a
// four-stage area pipeline. A fan that finds a matching triangle ends early, and a fan without
// one ends the query. A query with fewer than two vertices answers at once. One word is worked
// on at a time; a new input word is taken while the previous result word is handed over.
`include "point_in_polygon_fan_test_core_assert.svh"

module point_in_polygon_fan_test_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // coord_x, coord_y
    input  logic [pipft_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // func
    input  logic [pipft_pkg::FUNC_W-1:0]     i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // inside_res, vertex_count, rejected, zero fill
    output logic [pipft_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        RK_VN,
        RK_A,
        RK_TRI
    } t_rd_kind;

    t_state                       r_state;
    logic [pipft_pkg::CNT_W-1:0]  r_count;
    logic [pipft_pkg::CNT_W-1:0]  r_k;
    logic [pipft_pkg::ADDR_W-1:0] r_n;
    logic [pipft_pkg::ADDR_W-1:0] r_addr;
    pipft_pkg::t_pt               r_p;
    logic                         r_out_vld;
    logic                         r_out_inside;
    logic                         r_out_rej;

    pipft_pkg::t_pt               r_vtx [pipft_pkg::MAX_VERTICES];
    pipft_pkg::t_pt               r_rd;
    logic                         r_rd_vld;
    t_rd_kind                     r_rd_kind;
    logic                         r_rd_last;
    pipft_pkg::t_pt               r_vn;
    pipft_pkg::t_pt               r_prev;

    logic                         w_s_acc;
    pipft_pkg::t_func             w_func;
    pipft_pkg::t_pt               w_in_pt;
    logic                         w_full;
    logic                         w_many;
    logic                         w_walk_go;
    logic                         w_wr_en;
    logic [pipft_pkg::ADDR_W-1:0] w_addr_nxt;
    logic                         w_last_fan;
    logic                         w_flush;
    pipft_pkg::t_tri_req          w_req;
    pipft_pkg::t_tri_res          w_res;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_tready);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_func     = pipft_pkg::t_func'(i_s_tuser);
    assign w_in_pt.x  = i_s_tdata[pipft_pkg::COORD_W-1:0];
    assign w_in_pt.y  = i_s_tdata[2*pipft_pkg::COORD_W-1:pipft_pkg::COORD_W];
    assign w_full     = (r_count == pipft_pkg::CNT_W'(pipft_pkg::MAX_VERTICES));
    assign w_many     = (r_count >= pipft_pkg::CNT_W'(2));
    assign w_walk_go  = w_s_acc && (w_func == pipft_pkg::FN_QUERY) && w_many;
    assign w_wr_en    = w_s_acc && (w_func == pipft_pkg::FN_APPEND) && !w_full;

    assign w_addr_nxt = (pipft_pkg::CNT_W'(r_addr) + pipft_pkg::CNT_W'(1) == r_count)
                      ? '0 : r_addr + pipft_pkg::ADDR_W'(1);
    assign w_last_fan = (pipft_pkg::CNT_W'(r_n) + pipft_pkg::CNT_W'(1) == r_count);
    assign w_flush    = w_res.vld && (w_res.hit || w_res.last) && (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_vtx[r_count[pipft_pkg::ADDR_W-1:0]] <= w_in_pt;
        end
        r_rd <= r_vtx[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && (r_rd_kind == RK_VN)) begin
            r_vn <= r_rd;
        end
        if (r_rd_vld && (r_rd_kind != RK_VN)) begin
            r_prev <= r_rd;
        end
    end

    assign w_req.vld  = r_rd_vld && (r_rd_kind == RK_TRI);
    assign w_req.last = r_rd_last;
    assign w_req.vn   = r_vn;
    assign w_req.a    = r_prev;
    assign w_req.b    = r_rd;
    assign w_req.p    = r_p;

    pipft_area_pipe u_area_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_flush),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_out_inside <= 1'b0;
                        r_out_rej    <= 1'b0;
                        r_out_vld    <= 1'b1;
                        unique case (w_func)
                            pipft_pkg::FN_APPEND: begin
                                if (w_full) begin
                                    r_out_rej <= 1'b1;
                                end else begin
                                    r_count <= r_count + pipft_pkg::CNT_W'(1);
                                end
                            end
                            pipft_pkg::FN_QUERY: begin
                                r_p    <= w_in_pt;
                                r_n    <= '0;
                                r_addr <= '0;
                                r_k    <= '0;
                                if (w_walk_go) begin
                                    r_out_vld <= 1'b0;
                                    r_state   <= ST_ISSUE;
                                end
                            end
                            pipft_pkg::FN_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ISSUE: begin
                    r_rd_vld  <= 1'b1;
                    r_rd_last <= (r_k == r_count);
                    if (r_k == '0) begin
                        r_rd_kind <= RK_VN;
                    end else if (r_k == pipft_pkg::CNT_W'(1)) begin
                        r_rd_kind <= RK_A;
                    end else begin
                        r_rd_kind <= RK_TRI;
                    end
                    r_k    <= r_k + pipft_pkg::CNT_W'(1);
                    r_addr <= w_addr_nxt;
                    if (r_k == r_count) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_flush) begin
                r_rd_vld <= 1'b0;
                if (w_res.hit && !w_last_fan) begin
                    r_n     <= r_n + pipft_pkg::ADDR_W'(1);
                    r_addr  <= r_n + pipft_pkg::ADDR_W'(1);
                    r_k     <= '0;
                    r_state <= ST_ISSUE;
                end else begin
                    r_out_vld    <= 1'b1;
                    r_out_inside <= w_res.hit;
                    r_out_rej    <= 1'b0;
                    r_state      <= ST_IDLE;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{pipft_pkg::OUT_PAD_W{1'b0}}, r_out_rej,
                         pipft_pkg::OUT_CNT_W'(r_count), r_out_inside};

    `PIPFT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, !r_count[pipft_pkg::ADDR_W] || w_full)
    `PIPFT_ASSERT_IMPL(a_rej_full, i_clk, i_rst_n, r_out_vld && r_out_rej, w_full)
    `PIPFT_ASSERT_IMPL(a_inside_two, i_clk, i_rst_n, r_out_vld && r_out_inside, w_many)
    `PIPFT_ASSERT_IMPL(a_pipe_busy, i_clk, i_rst_n, w_res.vld || r_rd_vld, r_state != ST_IDLE)
    `PIPFT_ASSERT_NEXT(a_walk_start, i_clk, i_rst_n, w_walk_go, r_state == ST_ISSUE && r_k == '0)

endmodule

### test/testbench.sv
// Self-checking testbench for point_in_polygon_fan_test_core: streams vertex, query and clear
// words, predicts every result word from its own copy of the polygon and checks each one.
// Depends on pipft_pkg and the core RTL.
module testbench;

    localparam logic [pipft_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int FULL_SPAN = 32768;

    typedef struct {
        logic                            in_poly;
        logic [pipft_pkg::OUT_CNT_W-1:0] count;
        logic                            rejected;
    } t_verdict;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [pipft_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [pipft_pkg::FUNC_W-1:0]     i_s_tuser = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [pipft_pkg::OUT_DATA_W-1:0] o_m_tdata;

    pipft_pkg::t_coord corner_x [pipft_pkg::MAX_VERTICES];
    pipft_pkg::t_coord corner_y [pipft_pkg::MAX_VERTICES];
    int                corner_count = 0;
    t_verdict          verdict_q[$];
    int                errors = 0;
    int                cycle_count = 0;
    bit                steady = 1'b0;

    point_in_polygon_fan_test_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("point_in_polygon_fan_test_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 36);
    end

    function automatic int next_corner(int i);
        return (i + 1 >= corner_count) ? 0 : i + 1;
    endfunction

    function automatic longint tri_area2(longint ax, longint ay, longint bx, longint by,
                                         longint cx, longint cy);
        longint s;
        s = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
        return (s < 0) ? -s : s;
    endfunction

    // Every vertex must own a fan triangle whose area equals the sum of the three areas
    // formed with the point; the walk includes the degenerate triangle closing at the vertex.
    function automatic bit covers_point(pipft_pkg::t_coord px, pipft_pkg::t_coord py);
        int     n, first, a, b;
        bit     hit, walking;
        longint whole, part;
        hit = 1'b0;
        for (n = 0; n < corner_count && (n == 0 || hit); n++) begin
            first = next_corner(n);
            a = first;
            hit = 1'b0;
            walking = 1'b1;
            while (walking) begin
                b = next_corner(a);
                if (b == first) begin
                    walking = 1'b0;
                end else begin
                    whole = tri_area2(corner_x[a], corner_y[a], corner_x[b], corner_y[b],
                                      corner_x[n], corner_y[n]);
                    part = tri_area2(corner_x[a], corner_y[a], corner_x[b], corner_y[b], px, py)
                         + tri_area2(corner_x[n], corner_y[n], corner_x[b], corner_y[b], px, py)
                         + tri_area2(corner_x[a], corner_y[a], corner_x[n], corner_y[n], px, py);
                    if (whole == part) begin
                        hit = 1'b1;
                        walking = 1'b0;
                    end else begin
                        a = b;
                    end
                end
            end
        end
        return hit;
    endfunction

    function automatic t_verdict apply_word(logic [pipft_pkg::FUNC_W-1:0] fn,
                                            pipft_pkg::t_coord x, pipft_pkg::t_coord y);
        t_verdict v;
        v.in_poly = 1'b0;
        v.rejected = 1'b0;
        case (fn)
            pipft_pkg::FN_APPEND: begin
                if (corner_count < pipft_pkg::MAX_VERTICES) begin
                    corner_x[corner_count] = x;
                    corner_y[corner_count] = y;
                    corner_count++;
                end else begin
                    v.rejected = 1'b1;
                end
            end
            pipft_pkg::FN_QUERY: v.in_poly = covers_point(x, y);
            pipft_pkg::FN_CLEAR: corner_count = 0;
            default: ;
        endcase
        v.count = corner_count[pipft_pkg::OUT_CNT_W-1:0];
        return v;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_verdict v;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result word %h arrived with no expectation", o_m_tdata);
                errors++;
            end else begin
                v = verdict_q.pop_front();
                if (o_m_tdata[0] !== v.in_poly) begin
                    $error("inside_res: expected %0d, got %0d", v.in_poly, o_m_tdata[0]);
                    errors++;
                end
                if (o_m_tdata[pipft_pkg::OUT_CNT_W:1] !== v.count) begin
                    $error("vertex_count: expected %0d, got %0d", v.count,
                           o_m_tdata[pipft_pkg::OUT_CNT_W:1]);
                    errors++;
                end
                if (o_m_tdata[pipft_pkg::OUT_CNT_W+1] !== v.rejected) begin
                    $error("rejected: expected %0d, got %0d", v.rejected,
                           o_m_tdata[pipft_pkg::OUT_CNT_W+1]);
                    errors++;
                end
                if (pipft_pkg::OUT_PAD_W > 0
                    && o_m_tdata[pipft_pkg::OUT_DATA_W-1:pipft_pkg::OUT_USED_W] !== '0) begin
                    $error("zero fill: expected 0, got %h",
                           o_m_tdata[pipft_pkg::OUT_DATA_W-1:pipft_pkg::OUT_USED_W]);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input logic [pipft_pkg::FUNC_W-1:0] fn,
                             input pipft_pkg::t_coord x, input pipft_pkg::t_coord y);
        logic [pipft_pkg::IN_DATA_W-1:0] word;
        word = '0;
        word[2*pipft_pkg::COORD_W-1:0] = {y, x};
        if (!steady) begin
            while ($urandom_range(99) < 36) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= fn;
        i_s_tdata <= word;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        verdict_q.insert(verdict_q.size(), apply_word(fn, x, y));
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic pipft_pkg::t_coord pick_coord(int span);
        if (span >= FULL_SPAN) return pipft_pkg::t_coord'($urandom_range(0, 65535));
        return pipft_pkg::t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_small_polygons();
        send_word(pipft_pkg::FN_QUERY, 16'sd0, 16'sd0);
        send_word(pipft_pkg::FN_APPEND, 16'sd0, 16'sd0);
        send_word(pipft_pkg::FN_QUERY, 16'sd0, 16'sd0);
        send_word(pipft_pkg::FN_APPEND, 16'sd10, 16'sd10);
        send_word(pipft_pkg::FN_QUERY, 16'sd5, 16'sd5);
        send_word(pipft_pkg::FN_QUERY, 16'sd20, 16'sd20);
        send_word(pipft_pkg::FN_QUERY, 16'sd5, 16'sd6);
        send_word(FN_UNUSED, -16'sd1, -16'sd1);
        send_word(pipft_pkg::FN_CLEAR, 16'sd0, 16'sd0);
        send_word(pipft_pkg::FN_APPEND, -16'sd32768, -16'sd32768);
        send_word(pipft_pkg::FN_APPEND, 16'sd32767, -16'sd32768);
        send_word(pipft_pkg::FN_APPEND, 16'sd0, 16'sd32767);
        send_word(pipft_pkg::FN_QUERY, 16'sd0, 16'sd0);
        send_word(pipft_pkg::FN_QUERY, -16'sd32768, -16'sd32768);
        send_word(pipft_pkg::FN_QUERY, 16'sd0, -16'sd32768);
        send_word(pipft_pkg::FN_QUERY, 16'sd32767, 16'sd32767);
        send_word(pipft_pkg::FN_QUERY, -16'sd32768, 16'sd32767);
        send_word(FN_UNUSED, 16'sd32767, -16'sd32768);
        send_word(pipft_pkg::FN_CLEAR, 16'sd0, 16'sd0);
    endtask

    // Vertices on a parabola arc give a convex polygon that fills the store.
    task automatic test_full_store();
        int i;
        for (i = 0; i < pipft_pkg::MAX_VERTICES; i++) begin
            send_word(pipft_pkg::FN_APPEND, pipft_pkg::t_coord'(i * 512 - 16384),
                      pipft_pkg::t_coord'(i * i * 8 - 16000));
        end
        send_word(pipft_pkg::FN_APPEND, pick_coord(FULL_SPAN), pick_coord(FULL_SPAN));
        send_word(pipft_pkg::FN_QUERY, 16'sd0, -16'sd2000);
        send_word(pipft_pkg::FN_QUERY, 16'sd0, -16'sd7808);
        send_word(pipft_pkg::FN_QUERY, -16'sd16128, -16'sd15996);
        send_word(pipft_pkg::FN_QUERY, 16'sd0, 16'sd30000);
        send_word(pipft_pkg::FN_CLEAR, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_polygons();
        int sent, round, span, sides, asks, i, k, kind, px, py;
        sent = 0;
        round = 0;
        while (sent < 60) begin
            steady = (round >= 6 && round < 10);
            case ($urandom_range(2))
                0: span = 8;
                1: span = 1000;
                default: span = FULL_SPAN;
            endcase
            if ($urandom_range(9) != 0 || corner_count > 40) begin
                send_word(pipft_pkg::FN_CLEAR, pick_coord(FULL_SPAN), pick_coord(FULL_SPAN));
                sent++;
            end
            sides = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            for (i = 0; i < sides; i++) begin
                send_word(pipft_pkg::FN_APPEND, pick_coord(span), pick_coord(span));
                sent++;
            end
            asks = $urandom_range(2, 5);
            for (i = 0; i < asks; i++) begin
                kind = (corner_count == 0) ? 0 : $urandom_range(4);
                k = (corner_count == 0) ? 0 : $urandom_range(corner_count - 1);
                case (kind)
                    1: begin
                        px = corner_x[k];
                        py = corner_y[k];
                    end
                    2: begin
                        px = (corner_x[k] + corner_x[next_corner(k)]) / 2;
                        py = (corner_y[k] + corner_y[next_corner(k)]) / 2;
                    end
                    3: begin
                        px = (corner_x[k] + corner_x[next_corner(k)]
                              + corner_x[next_corner(next_corner(k))]) / 3;
                        py = (corner_y[k] + corner_y[next_corner(k)]
                              + corner_y[next_corner(next_corner(k))]) / 3;
                    end
                    4: begin
                        px = pick_coord(FULL_SPAN);
                        py = pick_coord(FULL_SPAN);
                    end
                    default: begin
                        px = pick_coord(span);
                        py = pick_coord(span);
                    end
                endcase
                send_word(pipft_pkg::FN_QUERY, pipft_pkg::t_coord'(px), pipft_pkg::t_coord'(py));
                sent++;
            end
            if ($urandom_range(3) == 0) begin
                send_word(FN_UNUSED, pick_coord(FULL_SPAN), pick_coord(FULL_SPAN));
            end
            if (round == 3 || $urandom_range(4) == 0) begin
                drain_results();
            end
            round++;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_small_polygons();
        test_full_store();
        test_random_polygons();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("point_in_polygon_fan_test_core regression: pass");
        end else begin
            $display("point_in_polygon_fan_test_core regression: fail");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/pipft_pkg.sv
sv/pipft_area_pipe.sv
sv/point_in_polygon_fan_test_core.sv
test/testbench.sv
